// ===== rtl/msh_pkg.sv =====
// Shared types and constants of the media sample header encoder.
package msh_pkg;

  // Widths of the clamped time values and of the packet length.
  localparam int MAG_W = 56;
  localparam int LEN_W = 33;

  // Byte counter width within one header field (up to eight bytes).
  localparam int CNT_W = 3;

  // Depth of the descriptor queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Largest magnitude that fits in seven bytes.
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // Configuration register indexes.
  localparam logic REG_SYNC_WORD = 1'b0;
  localparam logic REG_SAMPLE_TYPE = 1'b1;

  // One classified sample, ready for serialization.
  typedef struct packed {
    logic [7:0]       stream_id;
    logic [7:0]       flags;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] dur;
    logic [LEN_W-1:0] len;
    logic [2:0]       ilen;
  } desc_t;

endpackage

// ===== rtl/msh_front.sv =====
// Front part: accepts samples, computes clamped times, byte counts and packet length.
module msh_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                stream_id,
  input  logic                      is_sync,
  input  logic                      time_valid,
  input  logic signed [56:0]        start_time,
  input  logic signed [56:0]        stop_time,
  input  logic [31:0]               payload_len,
  input  logic                      end_of_stream,
  output logic                      q_push,
  output msh_pkg::desc_t            q_data,
  input  logic                      q_full
);

  // Number of bytes of a clamped time value, up to its highest nonzero byte.
  function automatic logic [2:0] mag_bytes(input logic [msh_pkg::MAG_W-1:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (v[i*8 +: 8] != 8'd0) n = 3'(i + 1);
    end
    return n;
  endfunction

  // Number of bytes for the packet length, at least one.
  function automatic logic [2:0] len_bytes(input logic [msh_pkg::LEN_W-1:0] v);
    logic [2:0] n;
    n = 3'd1;
    for (int i = 1; i < 4; i++) begin
      if (v[i*8 +: 8] != 8'd0) n = 3'(i + 1);
    end
    if (v[32]) n = 3'd5;
    return n;
  endfunction

  // Stage A registers: clamped magnitude and duration.
  logic                      a_valid;
  logic [7:0]                a_stream_id;
  logic                      a_is_sync;
  logic                      a_neg;
  logic [msh_pkg::MAG_W-1:0] a_mag;
  logic [msh_pkg::MAG_W-1:0] a_dur;
  logic [31:0]               a_payload_len;

  // Stage B registers: the finished descriptor.
  logic                      b_valid;
  msh_pkg::desc_t            b_desc;

  logic a_ready, b_ready, accept;
  logic [56:0] abs_start;
  logic [57:0] diff;
  logic [msh_pkg::MAG_W-1:0] mag_val, dur_val;
  logic neg_val;
  logic [2:0] its, idur;
  logic [msh_pkg::LEN_W-1:0] len_val;

  // Pipeline flow control; stage B advances when it is empty or the queue has room.
  assign b_ready = !b_valid || !q_full;
  assign a_ready = !a_valid || b_ready;
  assign full    = !a_ready;
  assign accept  = push && a_ready;

  // Magnitude of the start time and the signed duration.
  assign abs_start = start_time[56] ? 57'(-start_time) : 57'(start_time);
  assign diff      = {stop_time[56], stop_time} - {start_time[56], start_time};

  always_comb begin
    mag_val = '0;
    dur_val = '0;
    neg_val = 1'b1;
    if (time_valid) begin
      neg_val = start_time[56];
      mag_val = abs_start[56] ? msh_pkg::MAG_MAX : abs_start[55:0];
      if (!diff[57] && diff != 58'd0) begin
        dur_val = diff[56] ? msh_pkg::MAG_MAX : diff[55:0];
      end
    end
  end

  // Stage A: an end-of-stream transaction is taken and dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= push && !end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_stream_id   <= stream_id;
      a_is_sync     <= is_sync;
      a_neg         <= neg_val;
      a_mag         <= mag_val;
      a_dur         <= dur_val;
      a_payload_len <= payload_len;
    end
  end

  // Byte counts and full-width packet length.
  assign its     = mag_bytes(a_mag);
  assign idur    = mag_bytes(a_dur);
  assign len_val = {1'b0, a_payload_len} + {30'd0, its} + {30'd0, idur}
                 + msh_pkg::LEN_W'(2);

  // Stage B.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_desc.stream_id <= a_stream_id;
      b_desc.flags     <= {a_is_sync, a_neg, its, idur};
      b_desc.mag       <= a_mag;
      b_desc.dur       <= a_dur;
      b_desc.len       <= len_val;
      b_desc.ilen      <= len_bytes(len_val);
    end
  end

  assign q_push = b_valid && !q_full;
  assign q_data = b_desc;

endmodule

// ===== rtl/msh_queue.sv =====
// Descriptor queue between the front and back parts.
module msh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_push,
  input  msh_pkg::desc_t wr_data,
  output logic           q_full,
  input  logic           rd_pop,
  output logic           rd_valid,
  output msh_pkg::desc_t rd_data
);

  msh_pkg::desc_t               entries [msh_pkg::QUEUE_DEPTH];
  logic [msh_pkg::QPTR_W-1:0]   wr_ptr;
  logic [msh_pkg::QPTR_W-1:0]   rd_ptr;
  logic [msh_pkg::QCNT_W-1:0]   count;

  assign q_full   = count == msh_pkg::QCNT_W'(msh_pkg::QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_push) wr_ptr <= wr_ptr + 1'b1;
      if (rd_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (wr_push && !rd_pop) begin
        count <= count + 1'b1;
      end else if (!wr_push && rd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill level never passes the depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= msh_pkg::QCNT_W'(msh_pkg::QUEUE_DEPTH))
    else $error("queue fill level above depth");

  // No write into a full queue unless an entry leaves in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    (wr_push && q_full) |-> rd_pop)
    else $error("write into full queue");

endmodule

// ===== rtl/msh_back.sv =====
// Back part: walks one descriptor's header fields, one byte per unstalled cycle.
module msh_back #(
  parameter int SYNC_BYTES = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    sync_word,
  input  logic [4:0]     sample_type,
  input  logic           q_valid,
  input  msh_pkg::desc_t q_data,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     header_byte,
  output logic           last_byte
);

  // Header field sequencer codes.
  localparam logic [2:0] PH_SYNC  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_ID    = 3'd3;
  localparam logic [2:0] PH_FLAGS = 3'd4;
  localparam logic [2:0] PH_TS    = 3'd5;
  localparam logic [2:0] PH_DUR   = 3'd6;

  localparam logic [msh_pkg::CNT_W-1:0] SYNC_LAST = msh_pkg::CNT_W'(SYNC_BYTES - 1);

  logic [2:0]                phase, phase_next;
  logic [msh_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                      out_valid;
  logic                      adv;
  logic [7:0]                byte_val;
  logic                      last_val;
  logic [2:0]                its, idur;
  logic [63:0]               sync64, len64, mag64, dur64;
  logic [5:0]                shamt;

  assign its    = q_data.flags[5:3];
  assign idur   = q_data.flags[2:0];
  assign sync64 = {32'd0, sync_word};
  assign len64  = {31'd0, q_data.len};
  assign mag64  = {8'd0, q_data.mag};
  assign dur64  = {8'd0, q_data.dur};
  assign shamt  = {cnt, 3'b000};

  // A queued byte moves into the output register when it is free or being taken.
  assign adv   = q_valid && (!out_valid || pop);
  assign q_pop = adv && last_val;
  assign empty = !out_valid;

  // Byte selection and sequencing.
  always_comb begin
    byte_val   = 8'd0;
    last_val   = 1'b0;
    phase_next = phase;
    cnt_next   = cnt - 1'b1;
    unique case (phase)
      PH_SYNC: begin
        byte_val = 8'(sync64 >> shamt);
        if (cnt == '0) phase_next = PH_TYPE;
      end
      PH_TYPE: begin
        byte_val   = {sample_type, q_data.ilen - 3'd1};
        phase_next = PH_LEN;
        cnt_next   = q_data.ilen - 3'd1;
      end
      PH_LEN: begin
        byte_val = 8'(len64 >> shamt);
        if (cnt == '0) phase_next = PH_ID;
      end
      PH_ID: begin
        byte_val   = q_data.stream_id;
        phase_next = PH_FLAGS;
      end
      PH_FLAGS: begin
        byte_val = q_data.flags;
        priority if (its != 3'd0) begin
          phase_next = PH_TS;
          cnt_next   = its - 3'd1;
        end else if (idur != 3'd0) begin
          phase_next = PH_DUR;
          cnt_next   = idur - 3'd1;
        end else begin
          last_val = 1'b1;
        end
      end
      PH_TS: begin
        byte_val = 8'(mag64 >> shamt);
        if (cnt == '0) begin
          if (idur != 3'd0) begin
            phase_next = PH_DUR;
            cnt_next   = idur - 3'd1;
          end else begin
            last_val = 1'b1;
          end
        end
      end
      PH_DUR: begin
        byte_val = 8'(dur64 >> shamt);
        if (cnt == '0) last_val = 1'b1;
      end
      default: begin
        phase_next = PH_SYNC;
        cnt_next   = SYNC_LAST;
      end
    endcase
    if (last_val) begin
      phase_next = PH_SYNC;
      cnt_next   = SYNC_LAST;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC;
      cnt   <= SYNC_LAST;
    end else if (adv) begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      header_byte <= byte_val;
      last_byte   <= last_val;
    end
  end

  // A descriptor leaves the queue only while one is there.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("descriptor popped from empty queue");

  // The final byte comes only from the flags, timestamp or duration field.
  assert property (@(posedge clk) disable iff (rst)
    (adv && last_val) |-> (phase == PH_FLAGS || phase == PH_TS || phase == PH_DUR))
    else $error("last byte flagged in wrong field");

  // Timestamp byte index stays below the timestamp byte count.
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && phase == PH_TS) |-> (cnt < its))
    else $error("timestamp byte index out of range");

  // The last byte of a transaction restarts the sync field at the next edge.
  assert property (@(posedge clk) disable iff (rst)
    (adv && last_val) |=> (phase == PH_SYNC && cnt == SYNC_LAST))
    else $error("sequencer did not restart after last byte");

endmodule

// ===== rtl/media_sample_header_encoder.sv =====
// Top level of the media sample header encoder: configuration registers and part wiring.
//
// Each accepted sample transaction yields its packet header as a byte stream, one byte per
// result transaction, most significant byte first, with last_byte set on the final byte;
// end-of-stream transactions yield nothing. A header is SYNC_BYTES + 4 to SYNC_BYTES + 22
// bytes long and the output sequencer emits one byte per cycle unless the output stalls;
// that byte sequencer sets the rate. A sample passes stage A, stage B, the queue and the
// output register before its first byte can be taken. Samples are taken back to back
// while a four-entry descriptor queue has room, so input and output stall independently.
// Configuration must be written only while the block is idle, which it does not enforce.
module media_sample_header_encoder #(
  parameter int SYNC_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port.
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [31:0]        wr_data,
  // Sample input queue side.
  input  logic               push,
  output logic               full,
  input  logic [7:0]         stream_id,
  input  logic               is_sync,
  input  logic               time_valid,
  input  logic signed [56:0] start_time,
  input  logic signed [56:0] stop_time,
  input  logic [31:0]        payload_len,
  input  logic               end_of_stream,
  // Header byte output queue side.
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         header_byte,
  output logic               last_byte
);

  logic [31:0]    sync_word;
  logic [4:0]     sample_type;
  logic           q_push, q_full, q_pop, q_valid;
  msh_pkg::desc_t q_wr_data, q_rd_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word   <= 32'h44534D53;
      sample_type <= 5'd4;
    end else if (wr_en) begin
      unique case (wr_index)
        msh_pkg::REG_SYNC_WORD:   sync_word   <= wr_data;
        msh_pkg::REG_SAMPLE_TYPE: sample_type <= wr_data[4:0];
        default: ;
      endcase
    end
  end

  msh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .stream_id     (stream_id),
    .is_sync       (is_sync),
    .time_valid    (time_valid),
    .start_time    (start_time),
    .stop_time     (stop_time),
    .payload_len   (payload_len),
    .end_of_stream (end_of_stream),
    .q_push        (q_push),
    .q_data        (q_wr_data),
    .q_full        (q_full)
  );

  msh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_push  (q_push),
    .wr_data  (q_wr_data),
    .q_full   (q_full),
    .rd_pop   (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  msh_back #(
    .SYNC_BYTES (SYNC_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .sync_word   (sync_word),
    .sample_type (sample_type),
    .q_valid     (q_valid),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .header_byte (header_byte),
    .last_byte   (last_byte)
  );

endmodule

// ===== bench/media_sample_header_encoder_tb.sv =====
// Self-checking testbench for the media sample header encoder.
`timescale 1ns / 1ps

module media_sample_header_encoder_tb;

  localparam int SYNC_BYTES = 4;
  // Cycles waited after every sample is taken and every expected byte is out.
  localparam int SETTLE_CYCLES = 40;
  localparam logic [56:0] TIME_MAX = 57'h0FFFFFFFFFFFFFF;
  localparam logic [56:0] TIME_MIN = 57'h100000000000000;
  localparam logic [57:0] TIME_CLAMP = 58'(msh_pkg::MAG_MAX);

  // One sample descriptor as the driver presents it.
  typedef struct packed {
    logic [7:0]  stream_id;
    logic        is_sync;
    logic        time_valid;
    logic [56:0] start_time;
    logic [56:0] stop_time;
    logic [31:0] payload_len;
    logic        end_of_stream;
  } sample_t;

  // One expected header byte.
  typedef struct {
    logic [7:0] hbyte;
    logic       last;
  } hdr_byte_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic               wr_index = 1'b0;
  logic [31:0]        wr_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         stream_id = '0;
  logic               is_sync = 1'b0;
  logic               time_valid = 1'b0;
  logic signed [56:0] start_time = '0;
  logic signed [56:0] stop_time = '0;
  logic [31:0]        payload_len = '0;
  logic               end_of_stream = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         header_byte;
  logic               last_byte;

  // Pending samples, expected header bytes and bookkeeping.
  sample_t   sample_q[$];
  hdr_byte_t hdr_q[$];
  sample_t   drv_sample;
  sample_t   seen_sample;
  hdr_byte_t want;
  int        samples_queued = 0;
  int        samples_taken = 0;
  int        errors = 0;
  int        idle_pct = 24;
  bit        in_fire = 1'b0;

  // Shadow copy of the configuration registers.
  logic [31:0] cfg_sync_word = 32'h44534D53;
  logic [4:0]  cfg_sample_type = 5'd4;

  media_sample_header_encoder #(
    .SYNC_BYTES(SYNC_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .push(push),
    .full(full),
    .stream_id(stream_id),
    .is_sync(is_sync),
    .time_valid(time_valid),
    .start_time(start_time),
    .stop_time(stop_time),
    .payload_len(payload_len),
    .end_of_stream(end_of_stream),
    .empty(empty),
    .pop(pop),
    .header_byte(header_byte),
    .last_byte(last_byte)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Number of bytes needed for a value, never fewer than floor_n.
  function automatic int count_bytes(input logic [63:0] v, input int floor_n);
    int n = 8;
    while (n > floor_n && v[(n - 1) * 8 +: 8] == 8'h00) n--;
    return n;
  endfunction

  // Appends the low n bytes of a field to the expected stream, MSB first.
  function automatic void append_field(input logic [63:0] v, input int n);
    hdr_byte_t b;
    for (int i = n - 1; i >= 0; i--) begin
      b.hbyte = v[i * 8 +: 8];
      b.last = 1'b0;
      hdr_q.push_back(b);
    end
  endfunction

  // Computes the header bytes of one accepted sample.
  function automatic void predict_header(input sample_t s);
    logic signed [57:0] st;
    logic signed [57:0] sp;
    logic signed [57:0] diff;
    logic [57:0]        mag;
    logic [57:0]        dur;
    logic [57:0]        len;
    int                 n_ts;
    int                 n_dur;
    int                 n_len;
    logic               neg;
    if (s.end_of_stream) return;
    mag = '0;
    dur = '0;
    n_ts = 0;
    n_dur = 0;
    neg = 1'b1;
    if (s.time_valid) begin
      st = {s.start_time[56], s.start_time};
      sp = {s.stop_time[56], s.stop_time};
      diff = sp - st;
      neg = st[57];
      mag = neg ? -st : st;
      if (mag > TIME_CLAMP) mag = TIME_CLAMP;
      // A stop before the start gives no duration.
      if (diff > 0) dur = diff;
      if (dur > TIME_CLAMP) dur = TIME_CLAMP;
      if (mag != 0) n_ts = count_bytes(64'(mag), 0);
      if (dur != 0) n_dur = count_bytes(64'(dur), 0);
    end
    len = 58'd2 + 58'(n_ts) + 58'(n_dur) + 58'(s.payload_len);
    n_len = count_bytes(64'(len), 1);
    append_field({32'h0, cfg_sync_word}, SYNC_BYTES);
    append_field(64'({cfg_sample_type, 3'(n_len - 1)}), 1);
    append_field(64'(len), n_len);
    append_field(64'(s.stream_id), 1);
    append_field(64'({s.is_sync, neg, 3'(n_ts), 3'(n_dur)}), 1);
    append_field(64'(mag), n_ts);
    append_field(64'(dur), n_dur);
    hdr_q[hdr_q.size() - 1].last = 1'b1;
  endfunction

  // Random time values of every byte length, both signs, and the extremes.
  function automatic logic [56:0] rand_time();
    logic [56:0] v;
    logic [56:0] b;
    v = 57'({$urandom(), $urandom()});
    b = 57'd1 << (8 * $urandom_range(7, 1));
    case ($urandom_range(4))
      0: return v;
      1: return v >> $urandom_range(56);
      2: return -(v >> $urandom_range(56));
      3: begin
        case ($urandom_range(3))
          0: return '0;
          1: return TIME_MAX;
          2: return TIME_MIN;
          default: return '1;
        endcase
      end
      default: return $urandom_range(1) ? b : b - 57'd1;
    endcase
  endfunction

  // Stop times mostly just after the start, sometimes anywhere or earlier.
  function automatic logic [56:0] rand_stop(input logic [56:0] st);
    logic [56:0] delta;
    delta = 57'({$urandom(), $urandom()}) >> $urandom_range(56);
    case ($urandom_range(9))
      6, 7: return rand_time();
      8: return st - delta;
      9: return st;
      default: return st + delta;
    endcase
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(9))
      5, 6, 7: return $urandom() >> $urandom_range(31);
      8: return '1;
      9: return 32'($urandom_range(255, 250));
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_sample(input logic [7:0] id, input logic sync, input logic tv,
                              input logic [56:0] st, input logic [56:0] sp,
                              input logic [31:0] len, input logic eos);
    sample_t s;
    s.stream_id = id;
    s.is_sync = sync;
    s.time_valid = tv;
    s.start_time = st;
    s.stop_time = sp;
    s.payload_len = len;
    s.end_of_stream = eos;
    sample_q.push_back(s);
    samples_queued++;
  endtask

  // Waits until every sample is taken and every header byte has come out.
  task automatic drain();
    while (samples_taken != samples_queued || hdr_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic run_random(input int n, input int idle);
    logic [56:0] st;
    idle_pct = idle;
    for (int i = 0; i < n; i++) begin
      st = rand_time();
      queue_sample(8'($urandom()), 1'($urandom()), $urandom_range(99) < 85, st,
                   rand_stop(st), rand_len(), $urandom_range(99) < 5);
    end
    drain();
  endtask

  // Sample driver: holds a transaction until it is taken, idles at random.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_fire) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drv_sample = sample_q.pop_front();
        push <= 1'b1;
        stream_id <= drv_sample.stream_id;
        is_sync <= drv_sample.is_sync;
        time_valid <= drv_sample.time_valid;
        start_time <= drv_sample.start_time;
        stop_time <= drv_sample.stop_time;
        payload_len <= drv_sample.payload_len;
        end_of_stream <= drv_sample.end_of_stream;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Output side stalls at random.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= $urandom_range(99) >= idle_pct;
    end
  end

  // Monitor: tracks register writes, predicts accepted samples, checks bytes.
  always @(posedge clk) begin
    if (rst) begin
      in_fire = 1'b0;
      cfg_sync_word = 32'h44534D53;
      cfg_sample_type = 5'd4;
    end else begin
      if (wr_en) begin
        case (wr_index)
          msh_pkg::REG_SYNC_WORD: cfg_sync_word = wr_data;
          msh_pkg::REG_SAMPLE_TYPE: cfg_sample_type = wr_data[4:0];
          default: ;
        endcase
      end
      in_fire = push && (full === 1'b0);
      if (in_fire) begin
        seen_sample.stream_id = stream_id;
        seen_sample.is_sync = is_sync;
        seen_sample.time_valid = time_valid;
        seen_sample.start_time = start_time;
        seen_sample.stop_time = stop_time;
        seen_sample.payload_len = payload_len;
        seen_sample.end_of_stream = end_of_stream;
        samples_taken++;
        predict_header(seen_sample);
      end
      if (pop && empty === 1'b0) begin
        if (hdr_q.size() == 0) begin
          $display("%0t: unexpected header byte, expected none, actual %h last %b",
                   $time, header_byte, last_byte);
          errors++;
        end else begin
          want = hdr_q.pop_front();
          if (header_byte !== want.hbyte) begin
            $display("%0t: header_byte mismatch, expected %h, actual %h",
                     $time, want.hbyte, header_byte);
            errors++;
          end
          if (last_byte !== want.last) begin
            $display("%0t: last_byte mismatch, expected %b, actual %b",
                     $time, want.last, last_byte);
            errors++;
          end
        end
      end
    end
  end

  // Main sequence: directed samples at reset settings, then random phases.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Plain sample, then a sync point without valid time.
    queue_sample(8'h01, 1'b0, 1'b1, 57'd100, 57'd200, 32'd0, 1'b0);
    queue_sample(8'h02, 1'b1, 1'b0, 57'd5, 57'd9, 32'd10, 1'b0);
    // End of stream gives nothing, whatever else it carries.
    queue_sample(8'hFF, 1'b1, 1'b1, TIME_MAX, TIME_MIN, '1, 1'b1);
    // Zero start and zero duration.
    queue_sample(8'h00, 1'b0, 1'b1, '0, '0, 32'd0, 1'b0);
    // Most negative start and huge duration both saturate.
    queue_sample(8'h80, 1'b1, 1'b1, TIME_MIN, TIME_MAX, 32'd1, 1'b0);
    // Stop before start gives zero duration, then a start of -1 with a stop of zero.
    queue_sample(8'h7F, 1'b0, 1'b1, TIME_MAX, TIME_MIN, 32'd2, 1'b0);
    queue_sample(8'h33, 1'b0, 1'b1, '1, '0, 32'd3, 1'b0);
    // Largest packet length, above 32 bits.
    queue_sample(8'hAA, 1'b1, 1'b1, TIME_MIN, TIME_MAX, '1, 1'b0);
    queue_sample(8'h55, 1'b0, 1'b0, '0, '0, 32'd0, 1'b0);
    // Length crossing into a second byte.
    queue_sample(8'h10, 1'b0, 1'b0, '0, '0, 32'd254, 1'b0);
    queue_sample(8'h11, 1'b0, 1'b0, '0, '0, 32'd253, 1'b0);
    queue_sample(8'hFF, 1'b1, 1'b0, TIME_MAX, TIME_MAX, '1, 1'b0);
    queue_sample(8'h5A, 1'b0, 1'b1, TIME_MAX, TIME_MAX, 32'd0, 1'b0);
    queue_sample(8'h3C, 1'b1, 1'b1, 57'd255, 57'd511, 32'h0001_0000, 1'b0);
    queue_sample(8'h00, 1'b0, 1'b0, '0, '0, 32'd0, 1'b1);
    drain();

    write_reg(msh_pkg::REG_SYNC_WORD, 32'h0000_0000);
    write_reg(msh_pkg::REG_SAMPLE_TYPE, 32'd0);
    run_random(80, 24);

    // All ones in both registers, with a stretch of no idling.
    write_reg(msh_pkg::REG_SYNC_WORD, 32'hFFFF_FFFF);
    write_reg(msh_pkg::REG_SAMPLE_TYPE, 32'd31);
    run_random(80, 0);

    write_reg(msh_pkg::REG_SYNC_WORD, $urandom());
    write_reg(msh_pkg::REG_SAMPLE_TYPE, $urandom());
    run_random(80, 24);

    write_reg(msh_pkg::REG_SYNC_WORD, 32'h4453_4D53);
    write_reg(msh_pkg::REG_SAMPLE_TYPE, 32'hFFFF_FFE4);
    run_random(80, 24);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
